### rtl/core/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // item field layout
    localparam int ENTRY_W     = 64;
    localparam int FRAME_W     = 55;
    localparam int PRESENT_BIT = 63;
    localparam int STATUS_W    = 2;
    localparam int UCOUNT_W    = 8;

    typedef logic [ENTRY_W-1:0]  t_entry;
    typedef logic [FRAME_W-1:0]  t_frame;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [UCOUNT_W-1:0] t_ucount;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [ADDR_W-1:0]   t_addr;

    // result status codes
    localparam t_status ST_ABSENT    = 2'd0;
    localparam t_status ST_STORED    = 2'd1;
    localparam t_status ST_DUPLICATE = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

endpackage

### rtl/core/pfd_if.sv
`timescale 1ns / 1ps

// input channel: one raw page-map word per item
interface pfd_in_if;
    logic            valid;
    logic            ready;
    pfd_pkg::t_entry map_entry;

    modport source (output valid, output map_entry, input ready);
    modport sink   (input valid, input map_entry, output ready);
endinterface

// output channel: one lookup result per item
interface pfd_out_if;
    logic             valid;
    logic             ready;
    pfd_pkg::t_status status;
    pfd_pkg::t_frame  frame_number;
    pfd_pkg::t_ucount unique_count;

    modport source (output valid, output status, output frame_number,
                    output unique_count, input ready);
    modport sink   (input valid, input status, input frame_number,
                    input unique_count, output ready);
endinterface

### rtl/core/pfd_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, one write and one registered read port
module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

### rtl/core/page_frame_dedup_filter.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Handshake
// i_in      in   map_entry[63:0]                           valid/ready
// o_out     out  status[1:0] frame_number[54:0]            valid/ready
//                unique_count[7:0]
//
// Sequence: one item at a time. An entry that is not present or has frame number
// zero goes through accept and emit only, as does a present entry while the table
// is empty. Any other present entry also passes through a scan of the seen-frame
// RAM read port, one entry per cycle, that covers all fill_count entries on a
// miss; a hit ends the scan early.
// Reset: synchronous, active low; clears the fill count and all control, and
// holds input ready low. The RAM needs no clearing, only entries below the
// fill count are read.
// Stalls: the result register holds an item while o_out.ready is low; the
// next item is still accepted and scanned, and waits in the emit state.
module page_frame_dedup_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfd_in_if.sink    i_in,
    pfd_out_if.source o_out
);
    import pfd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    // control
    logic [1:0] r_state, n_state;
    t_count     r_fill, n_fill;
    t_count     r_addr, n_addr;     // next table entry to read
    logic       r_rd_pend, n_rd_pend; // read data arrives this cycle
    logic       r_last, n_last;       // pending read is the last valid entry
    logic       r_out_valid, n_out_valid;

    // item being worked on
    t_frame     r_frame, n_frame;
    t_status    r_status, n_status;

    // result register
    t_status    r_out_status;
    t_frame     r_out_frame;
    t_ucount    r_out_ucount;
    logic       out_load;

    // RAM side
    logic       ram_re;
    logic       ram_we;
    t_frame     ram_rdata;

    logic [CNT_W+UCOUNT_W-1:0] ucount_ext;
    t_frame     in_frame;
    logic       out_free;
    logic       issue;

    pfd_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (r_frame),
        .i_re    (ram_re),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // no item is taken while reset is held
    assign i_in.ready         = i_rst_n && (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.frame_number = r_out_frame;
    assign o_out.unique_count = r_out_ucount;

    assign in_frame   = i_in.map_entry[FRAME_W-1:0];
    assign out_free   = !r_out_valid || o_out.ready;
    assign issue      = (r_addr < r_fill);
    // count after this item, low bits only when the table is deeper than 255
    assign ucount_ext = {{UCOUNT_W{1'b0}}, n_fill};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_addr      = r_addr;
        n_rd_pend   = r_rd_pend;
        n_last      = r_last;
        n_frame     = r_frame;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_out.ready;
        out_load    = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_frame   = in_frame;
                    n_addr    = '0;
                    n_rd_pend = 1'b0;
                    n_last    = 1'b0;
                    if (!i_in.map_entry[PRESENT_BIT] || in_frame == '0) begin
                        n_frame  = '0;
                        n_status = ST_ABSENT;
                        n_state  = S_EMIT;
                    end else if (r_fill == '0) begin
                        // empty table: nothing to search
                        n_status = ST_STORED;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // read one entry per cycle, compare it in the cycle after its read
                ram_re    = issue;
                n_rd_pend = issue;
                n_last    = issue && (t_count'(r_addr + 1'b1) == r_fill);
                if (issue) begin
                    n_addr = t_count'(r_addr + 1'b1);
                end
                if (r_rd_pend && ram_rdata == r_frame) begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_EMIT;
                end else if (r_rd_pend && r_last) begin
                    n_status = (r_fill < t_count'(TABLE_DEPTH)) ? ST_STORED : ST_FULL;
                    n_state  = S_EMIT;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_status == ST_STORED) begin
                        ram_we = 1'b1;
                        n_fill = t_count'(r_fill + 1'b1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_addr      <= n_addr;
            r_rd_pend   <= n_rd_pend;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame  <= n_frame;
        r_status <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_frame  <= r_frame;
            r_out_ucount <= ucount_ext[UCOUNT_W-1:0];
        end
    end

endmodule
